[rtl/spf_pkg.sv]
// shared widths, register indexes and clamp helpers for the servo position follower
`default_nettype none

package spf_pkg;

  // operand and product widths of the shared multiplier, and the other data and index widths
  localparam int unsigned OpAW   = 33;
  localparam int unsigned OpBW   = 17;
  localparam int unsigned ProdW  = OpAW + OpBW;
  localparam int unsigned LimW   = 31;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DtW    = 16;
  localparam int unsigned QW     = 32;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxAcc  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxVel  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAccGain = 2'd2;
  localparam logic [CfgIdxW-1:0] RegVelGain = 2'd3;

  // reset values of the configuration registers
  localparam logic [LimW-1:0]  MaxAccReset  = 31'd655360;
  localparam logic [LimW-1:0]  MaxVelReset  = 31'd655360;
  localparam logic [GainW-1:0] AccGainReset = 16'd2560;
  localparam logic [GainW-1:0] VelGainReset = 16'd512;

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [QW-1:0]    q16_t;

  // symmetric clamp of a wide value to +/- lim
  function automatic q16_t spf_clamp(input prod_t x, input logic [LimW-1:0] lim);
    prod_t hi;
    prod_t lo;
    hi = $signed({{(ProdW-LimW){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      spf_clamp = q16_t'(hi);
    end else if (x < lo) begin
      spf_clamp = q16_t'(lo);
    end else begin
      spf_clamp = q16_t'(x);
    end
  endfunction

  // saturation to the signed 32-bit range
  function automatic q16_t spf_sat32(input prod_t x);
    prod_t hi;
    prod_t lo;
    hi = $signed({{(ProdW-QW+1){1'b0}}, {(QW-1){1'b1}}});
    lo = $signed({{(ProdW-QW+1){1'b1}}, {(QW-1){1'b0}}});
    if (x > hi) begin
      spf_sat32 = q16_t'(hi);
    end else if (x < lo) begin
      spf_sat32 = q16_t'(lo);
    end else begin
      spf_sat32 = q16_t'(x);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/spf_mul.sv]
// shared signed multiplier with registered product
`default_nettype none

module spf_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [spf_pkg::OpAW-1:0]   a_i,
  input  logic signed [spf_pkg::OpBW-1:0]   b_i,
  output logic signed [spf_pkg::ProdW-1:0]  p_o
);
  import spf_pkg::*;

  prod_t p_q;

  // one product per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/servo_position_follower.sv]
// servo position follower: cascaded proportional loop with velocity and acceleration limits
//
// Input channel (in_valid_i / in_ready_o) moves one word per control tick: a target
// position (signed Q16.16) and a tick length (unsigned Q0.16 s). Output channel
// (out_valid_o / out_ready_i) returns the new position, velocity and the applied
// acceleration for that tick, all signed Q16.16.
// One multiplier is shared by the four products of a tick (velocity demand,
// acceleration, velocity step, position step). Each product passes through a
// multiply state (ST_MUL) and a shift/add/clamp state (ST_POST). The result
// enters the output register at the end of the position step; the sequencer then
// returns to ST_IDLE and only there takes the next word.
// The output register is separate from the sequencer, so the next word is taken
// while a result waits; a tick only stalls in its last step if the previous result
// has still not been taken.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), taken at
// any edge; write it only while the block is idle.
// Reset clears position and velocity to zero and loads the default limits
// (10.0 per second and per second squared) and gains (10.0 and 2.0).
`default_nettype none

module servo_position_follower (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [spf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [spf_pkg::LimW-1:0]           cfg_data_i,
  // input word
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [spf_pkg::QW-1:0]      target_position_i,
  input  logic [spf_pkg::DtW-1:0]            delta_time_i,
  // output word
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spf_pkg::QW-1:0]      position_o,
  output logic signed [spf_pkg::QW-1:0]      velocity_o,
  output logic signed [spf_pkg::QW-1:0]      acceleration_o
);
  import spf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST
  } state_e;

  // step codes of the sequencer
  localparam logic [1:0] StepVdem = 2'd0;
  localparam logic [1:0] StepAcc  = 2'd1;
  localparam logic [1:0] StepVel  = 2'd2;
  localparam logic [1:0] StepPos  = 2'd3;

  logic [LimW-1:0]  max_acc_q, max_vel_q;
  logic [GainW-1:0] acc_gain_q, vel_gain_q;

  state_e              state_q;
  logic [1:0]          step_q;
  logic [DtW-1:0]      dt_q;
  q16_t                pos_q, vel_q, acc_q;
  logic signed [OpAW-1:0] op_a_q;
  logic signed [OpBW-1:0] op_b_q;
  logic                out_valid_q;
  q16_t                out_pos_q, out_vel_q, out_acc_q;

  prod_t           prod;
  prod_t           shifted, addend, sum;
  logic [LimW-1:0] lim;
  q16_t            clamped, saturated;
  logic            in_acc, out_free, last_go;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_acc_q  <= MaxAccReset;
      max_vel_q  <= MaxVelReset;
      acc_gain_q <= AccGainReset;
      vel_gain_q <= VelGainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxAcc:  max_acc_q  <= cfg_data_i;
        RegMaxVel:  max_vel_q  <= cfg_data_i;
        RegAccGain: acc_gain_q <= cfg_data_i[GainW-1:0];
        RegVelGain: vel_gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier
  spf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (state_q == ST_MUL),
    .a_i   (op_a_q),
    .b_i   (op_b_q),
    .p_o   (prod)
  );

  // shared shift, add, clamp and saturate unit
  always_comb begin
    shifted = (step_q inside {StepVdem, StepAcc}) ? (prod >>> 8) : (prod >>> 16);
    case (step_q)
      StepVel: addend = {{(ProdW-QW){vel_q[QW-1]}}, vel_q};
      StepPos: addend = {{(ProdW-QW){pos_q[QW-1]}}, pos_q};
      default: addend = '0;
    endcase
    sum       = shifted + addend;
    lim       = (step_q == StepAcc) ? max_acc_q : max_vel_q;
    clamped   = spf_clamp(sum, lim);
    saturated = spf_sat32(sum);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_go    = (state_q == ST_POST) && (step_q == StepPos) && out_free;

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepVdem;
      dt_q        <= '0;
      pos_q       <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      op_a_q      <= '0;
      op_b_q      <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_vel_q   <= '0;
      out_acc_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !last_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            dt_q    <= delta_time_i;
            op_a_q  <= {target_position_i[QW-1], target_position_i} - {pos_q[QW-1], pos_q};
            op_b_q  <= {1'b0, vel_gain_q};
            step_q  <= StepVdem;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_POST;
        end
        ST_POST: begin
          case (step_q)
            StepVdem: begin
              op_a_q  <= {clamped[QW-1], clamped} - {vel_q[QW-1], vel_q};
              op_b_q  <= {1'b0, acc_gain_q};
              step_q  <= StepAcc;
              state_q <= ST_MUL;
            end
            StepAcc: begin
              acc_q   <= clamped;
              op_a_q  <= {clamped[QW-1], clamped};
              op_b_q  <= {1'b0, dt_q};
              step_q  <= StepVel;
              state_q <= ST_MUL;
            end
            StepVel: begin
              vel_q   <= clamped;
              op_a_q  <= {clamped[QW-1], clamped};
              op_b_q  <= {1'b0, dt_q};
              step_q  <= StepPos;
              state_q <= ST_MUL;
            end
            default: begin
              if (out_free) begin
                pos_q       <= saturated;
                out_pos_q   <= saturated;
                out_vel_q   <= vel_q;
                out_acc_q   <= acc_q;
                out_valid_q <= 1'b1;
                step_q      <= StepVdem;
                state_q     <= ST_IDLE;
              end
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = out_pos_q;
  assign velocity_o     = out_vel_q;
  assign acceleration_o = out_acc_q;

  // an accepted word starts the first multiply
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MUL && step_q == StepVdem))
    else $error("accepted word did not start the sequencer");

  // a finished tick never overwrites an untaken result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POST && step_q == StepPos && out_valid_q && !out_ready_i)
      |=> (state_q == ST_POST && step_q == StepPos))
    else $error("result register overwritten while stalled");

  // delivered velocity lies within its limit
  a_vel_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (velocity_o <= $signed({1'b0, max_vel_q}) &&
                     velocity_o >= -$signed({1'b0, max_vel_q})))
    else $error("velocity beyond limit");

  // delivered acceleration lies within its limit
  a_acc_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (acceleration_o <= $signed({1'b0, max_acc_q}) &&
                     acceleration_o >= -$signed({1'b0, max_acc_q})))
    else $error("acceleration beyond limit");

endmodule

`default_nettype wire
